// ===== design/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types, register indexes and fixed-point helpers for the box
// boundary reflection pipeline.
// ----------------------------------------------------------------------------
package bbr_pkg;

  // Signed Q16.16 value and a three-component vector of them.
  typedef logic signed [31:0] q16_t;
  typedef q16_t vec3_t [3];

  // Load enables for the two register stages inside one lane.
  typedef struct packed {
    logic stage_a;
    logic stage_b;
  } bbr_ctl_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_FWD_X  = 3'd0;
  localparam logic [2:0] REG_FWD_Y  = 3'd1;
  localparam logic [2:0] REG_FWD_Z  = 3'd2;
  localparam logic [2:0] REG_INV_X  = 3'd3;
  localparam logic [2:0] REG_INV_Y  = 3'd4;
  localparam logic [2:0] REG_INV_Z  = 3'd5;
  localparam logic [2:0] REG_MARGIN = 3'd6;
  localparam logic [2:0] REG_REST   = 3'd7;

  // Register reset values (unit x and y rows, a z row of one half, small
  // margin, half bounce).
  localparam logic [63:0] ROW_X_RESET  = 64'h0000_0000_0000_0800;
  localparam logic [63:0] ROW_Y_RESET  = 64'h0000_0000_0800_0000;
  localparam logic [63:0] ROW_Z_RESET  = 64'h0000_0400_0000_0000;
  localparam logic [15:0] MARGIN_RESET = 16'd66;
  localparam logic [15:0] REST_RESET   = 16'd32768;

  // One in Q16.16, the upper wall of the unit box.
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  localparam logic signed [40:0] SAT_MAX = 41'sd2147483647;
  localparam logic signed [40:0] SAT_MIN = -SAT_MAX - 41'sd1;

  // Signed Q5.11 word k of a packed matrix row.
  function automatic logic signed [15:0] row_word(input logic [63:0] row,
                                                  input logic [1:0] k);
    return $signed(row[16*k +: 16]);
  endfunction

  // Clamp a wide value to the signed 32-bit range.
  function automatic q16_t sat_q16(input logic signed [40:0] v);
    q16_t r;
    if (v > SAT_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q.27 sum to Q16.16: round half up, then saturate.
  function automatic q16_t round_sat11(input logic signed [50:0] acc);
    logic signed [51:0] biased;
    logic signed [40:0] shifted;
    biased  = 52'(acc) + 52'sd1024;
    shifted = 41'(biased >>> 11);
    return sat_q16(shifted);
  endfunction

endpackage

// ===== design/bbr_affine_lane.sv =====
// ----------------------------------------------------------------------------
// bbr_affine_lane
// One matrix row applied to a position (with translation) and a velocity
// (without). Products are registered, then summed, rounded and saturated.
// ----------------------------------------------------------------------------
module bbr_affine_lane (
  input  logic             clk,
  input  bbr_pkg::bbr_ctl_t ctl,
  input  logic [63:0]      row,
  input  bbr_pkg::vec3_t   pos_in,
  input  bbr_pkg::vec3_t   vel_in,
  output bbr_pkg::q16_t    pos_out,
  output bbr_pkg::q16_t    vel_out
);
  import bbr_pkg::*;

  logic signed [47:0] pos_prod [3];
  logic signed [47:0] vel_prod [3];
  logic signed [15:0] trans;
  logic signed [50:0] trans_term;
  logic signed [50:0] pos_acc;
  logic signed [50:0] vel_acc;

  // First stage: one 16x32 product per component.
  always_ff @(posedge clk) begin
    if (ctl.stage_a) begin
      for (int i = 0; i < 3; i++) begin
        pos_prod[i] <= row_word(row, 2'(i)) * pos_in[i];
        vel_prod[i] <= row_word(row, 2'(i)) * vel_in[i];
      end
    end
  end

  // The translation word scaled from Q5.11 to Q.27.
  assign trans      = row_word(row, 2'd3);
  assign trans_term = $signed({{19{trans[15]}}, trans, 16'b0});

  always_comb begin
    pos_acc = 51'(pos_prod[0]) + 51'(pos_prod[1]) + 51'(pos_prod[2]) + trans_term;
    vel_acc = 51'(vel_prod[0]) + 51'(vel_prod[1]) + 51'(vel_prod[2]);
  end

  // Second stage: round to Q16.16 and saturate.
  always_ff @(posedge clk) begin
    if (ctl.stage_b) begin
      pos_out <= round_sat11(pos_acc);
      vel_out <= round_sat11(vel_acc);
    end
  end

endmodule

// ===== design/bbr_bounce_lane.sv =====
// ----------------------------------------------------------------------------
// bbr_bounce_lane
// Wall test for one axis of the unit box. On a hit the position is moved
// to the inset and the velocity is scaled by minus the restitution.
// ----------------------------------------------------------------------------
module bbr_bounce_lane (
  input  logic              clk,
  input  bbr_pkg::bbr_ctl_t ctl,
  input  logic [15:0]       margin,
  input  logic [15:0]       rest,
  input  bbr_pkg::q16_t     pos_in,
  input  bbr_pkg::q16_t     vel_in,
  output bbr_pkg::q16_t     pos_out,
  output bbr_pkg::q16_t     vel_out
);
  import bbr_pkg::*;

  q16_t               pos_clamped;
  logic               hit;
  q16_t               pos_held;
  q16_t               vel_held;
  logic               hit_held;
  logic signed [48:0] prod;
  logic signed [49:0] neg_prod;
  logic signed [49:0] biased;
  logic signed [40:0] scaled;

  // Positions exactly on a wall count as inside.
  always_comb begin
    hit         = 1'b0;
    pos_clamped = pos_in;
    if (pos_in < 32'sd0) begin
      hit         = 1'b1;
      pos_clamped = $signed({16'b0, margin});
    end else if (pos_in > ONE_Q16) begin
      hit         = 1'b1;
      pos_clamped = ONE_Q16 - $signed({16'b0, margin});
    end
  end

  // First stage: clamp and the velocity times restitution product.
  always_ff @(posedge clk) begin
    if (ctl.stage_a) begin
      pos_held <= pos_clamped;
      vel_held <= vel_in;
      hit_held <= hit;
      prod     <= vel_in * $signed({1'b0, rest});
    end
  end

  // Negate, round half up from Q.32 to Q16.16.
  always_comb begin
    neg_prod = -50'(prod);
    biased   = neg_prod + 50'sd32768;
    scaled   = 41'(biased >>> 16);
  end

  // Second stage: pick the bounced or the unchanged velocity.
  always_ff @(posedge clk) begin
    if (ctl.stage_b) begin
      pos_out <= pos_held;
      vel_out <= hit_held ? sat_q16(scaled) : vel_held;
    end
  end

endmodule

// ===== design/box_boundary_reflect.sv =====
// ----------------------------------------------------------------------------
// box_boundary_reflect
// Keeps a particle inside an affinely placed unit box, bouncing it off the
// walls with restitution.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel carries one particle's world position
//   and velocity (Q16.16). It is taken at a clock edge with in_valid high
//   and in_stall low. The result leaves on the output channel one request
//   per particle, taken when out_valid is high and out_stall low.
//   There are six register stages: two for the inverse map, two for the
//   wall test and bounce, two for the forward map. The accepting edge
//   loads the first, and out_valid rises once the particle has moved on
//   into the sixth; the result is taken at an edge with out_stall low.
//   Throughput is one particle per cycle while out_stall is low, with three
//   axis lanes per map; each map's first stage holds its 16x32 multipliers.
//   When the receiver stalls, the held result stays unchanged and the
//   stages behind it keep filling their empty slots; in_stall rises only
//   once every stage holds a particle.
//   Matrices, margin and restitution are written through cfg_write,
//   cfg_index and cfg_data; the user must write them only while no
//   particle is in flight, as the block does not enforce it. Synchronous
//   reset empties the pipeline and loads the default matrices (unit x and y
//   rows, a z row of one half), a margin of 66 and a restitution of one half.
// ----------------------------------------------------------------------------
module box_boundary_reflect (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  vel_x,
  input  logic signed [31:0]  vel_y,
  input  logic signed [31:0]  vel_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  new_pos_x,
  output logic signed [31:0]  new_pos_y,
  output logic signed [31:0]  new_pos_z,
  output logic signed [31:0]  new_vel_x,
  output logic signed [31:0]  new_vel_y,
  output logic signed [31:0]  new_vel_z
);
  import bbr_pkg::*;

  logic [63:0] fwd_row [3];
  logic [63:0] inv_row [3];
  logic [15:0] margin;
  logic [15:0] rest;

  logic [6:1]  stage_valid;
  logic [7:1]  stage_en;
  logic [6:1]  valid_in;

  bbr_ctl_t    inv_ctl;
  bbr_ctl_t    bnc_ctl;
  bbr_ctl_t    fwd_ctl;

  vec3_t       world_pos;
  vec3_t       world_vel;
  vec3_t       unit_pos;
  vec3_t       unit_vel;
  vec3_t       bnc_pos;
  vec3_t       bnc_vel;
  vec3_t       out_pos;
  vec3_t       out_vel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_row[0] <= ROW_X_RESET;
      fwd_row[1] <= ROW_Y_RESET;
      fwd_row[2] <= ROW_Z_RESET;
      inv_row[0] <= ROW_X_RESET;
      inv_row[1] <= ROW_Y_RESET;
      inv_row[2] <= ROW_Z_RESET;
      margin     <= MARGIN_RESET;
      rest       <= REST_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FWD_X:  fwd_row[0] <= cfg_data;
        REG_FWD_Y:  fwd_row[1] <= cfg_data;
        REG_FWD_Z:  fwd_row[2] <= cfg_data;
        REG_INV_X:  inv_row[0] <= cfg_data;
        REG_INV_Y:  inv_row[1] <= cfg_data;
        REG_INV_Z:  inv_row[2] <= cfg_data;
        REG_MARGIN: margin     <= cfg_data[15:0];
        REG_REST:   rest       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    stage_en[7] = !out_stall;
    for (int k = 6; k >= 1; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  assign valid_in = {stage_valid[5:1], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int k = 1; k <= 6; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= valid_in[k];
        end
      end
    end
  end

  assign in_stall  = !stage_en[1];
  assign out_valid = stage_valid[6];

  assign inv_ctl = '{stage_a: stage_en[1], stage_b: stage_en[2]};
  assign bnc_ctl = '{stage_a: stage_en[3], stage_b: stage_en[4]};
  assign fwd_ctl = '{stage_a: stage_en[5], stage_b: stage_en[6]};

  assign world_pos = '{pos_x, pos_y, pos_z};
  assign world_vel = '{vel_x, vel_y, vel_z};

  // One lane per axis for each map; the forward lanes merge all three
  // bounced components into each world-frame output.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    bbr_affine_lane u_inv (
      .clk     (clk),
      .ctl     (inv_ctl),
      .row     (inv_row[a]),
      .pos_in  (world_pos),
      .vel_in  (world_vel),
      .pos_out (unit_pos[a]),
      .vel_out (unit_vel[a])
    );

    bbr_bounce_lane u_bnc (
      .clk     (clk),
      .ctl     (bnc_ctl),
      .margin  (margin),
      .rest    (rest),
      .pos_in  (unit_pos[a]),
      .vel_in  (unit_vel[a]),
      .pos_out (bnc_pos[a]),
      .vel_out (bnc_vel[a])
    );

    bbr_affine_lane u_fwd (
      .clk     (clk),
      .ctl     (fwd_ctl),
      .row     (fwd_row[a]),
      .pos_in  (bnc_pos),
      .vel_in  (bnc_vel),
      .pos_out (out_pos[a]),
      .vel_out (out_vel[a])
    );
  end

  assign new_pos_x = out_pos[0];
  assign new_pos_y = out_pos[1];
  assign new_pos_z = out_pos[2];
  assign new_vel_x = out_vel[0];
  assign new_vel_y = out_vel[1];
  assign new_vel_z = out_vel[2];

endmodule

// ===== design/bbr_checker.sv =====
// ----------------------------------------------------------------------------
// bbr_checker
// Port-level checks for the box boundary reflection pipeline.
// ----------------------------------------------------------------------------
module bbr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] new_pos_x,
  input logic signed [31:0] new_vel_z
);

  logic flow_ok;

  assign flow_ok = !out_stall && !rst;

  // A held result keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(new_pos_x) && $stable(new_vel_z))
    else $error("result changed while stalled");

  // The input side only backs up when a finished result is being held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // With the receiver free, an accepted request comes out on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(in_valid && !in_stall && !rst, 6) && $past(flow_ok, 1) && $past(flow_ok, 2)
      && $past(flow_ok, 3) && $past(flow_ok, 4) && $past(flow_ok, 5) |-> out_valid)
    else $error("result missing six cycles after accept");

endmodule

bind box_boundary_reflect bbr_checker u_bbr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .new_pos_x (new_pos_x),
  .new_vel_z (new_vel_z)
);
